>>> rtl/core/itoa_pkg.sv
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared types and constants for the signed integer to decimal text converter.
// ----------------------------------------------------------------------------
package itoa_pkg;

  localparam int unsigned ValueW  = 32;
  localparam int unsigned CharW   = 6;
  localparam int unsigned Digits  = 10;
  localparam int unsigned BcdW    = 4 * Digits;
  localparam int unsigned IterW   = $clog2(ValueW);
  localparam int unsigned NdW     = $clog2(Digits + 1);

  localparam logic [CharW-1:0] CharMinus = 6'd45;
  localparam logic [CharW-1:0] CharZero  = 6'd48;

  localparam logic [IterW-1:0] IterLast = IterW'(ValueW - 1);
  localparam logic [NdW-1:0]   NdFull   = NdW'(Digits);
  localparam logic [NdW-1:0]   NdOne    = NdW'(1);

  // Commands from controller to datapath
  typedef struct packed {
    logic load;
    logic dabble;
    logic skip;
    logic emit_sign;
    logic emit_digit;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic iter_done;
    logic top_zero;
    logic nd_one;
    logic neg;
    logic out_free;
  } status_t;

endpackage

>>> rtl/core/itoa_ctrl.sv
// ----------------------------------------------------------------------------
// itoa_ctrl
// Sequencer: load, 32 shift-add-3 steps, leading-zero skip, character emit.
// ----------------------------------------------------------------------------
module itoa_ctrl import itoa_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    StIdle,
    StConv,
    StSkip,
    StSign,
    StDigit
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StConv;
        end
      end
      StConv: begin
        cmd_o.dabble = 1'b1;
        if (status_i.iter_done) state_d = StSkip;
      end
      StSkip: begin
        if (status_i.top_zero && !status_i.nd_one) begin
          cmd_o.skip = 1'b1;
        end else if (status_i.neg) begin
          state_d = StSign;
        end else begin
          state_d = StDigit;
        end
      end
      StSign: begin
        if (status_i.out_free) begin
          cmd_o.emit_sign = 1'b1;
          state_d         = StDigit;
        end
      end
      StDigit: begin
        if (status_i.out_free) begin
          cmd_o.emit_digit = 1'b1;
          if (status_i.nd_one) state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != StIdle);

endmodule

>>> rtl/core/itoa_dp.sv
// ----------------------------------------------------------------------------
// itoa_dp
// Datapath: magnitude shifter, BCD register with add-3 correction, digit
// counter and the output register.
// ----------------------------------------------------------------------------
module itoa_dp import itoa_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [ValueW-1:0] value_i,
  input  cmd_t              cmd_i,
  output status_t           status_o,
  output logic [CharW-1:0]  character_o,
  output logic              last_o,
  output logic              out_valid_o,
  input  logic              out_stall_i
);

  logic [ValueW-1:0] mag_q, mag_d;
  logic [BcdW-1:0]   bcd_q, bcd_d, bcd_adj;
  logic [IterW-1:0]  iter_q, iter_d;
  logic [NdW-1:0]    nd_q, nd_d;
  logic              neg_q, neg_d;
  logic              out_valid_q, out_valid_d;
  logic [CharW-1:0]  char_q, char_d;
  logic              last_q, last_d;
  logic [3:0]        top_digit;

  assign top_digit = bcd_q[BcdW-1 -: 4];

  // Add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < Digits; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  always_comb begin
    mag_d       = mag_q;
    bcd_d       = bcd_q;
    iter_d      = iter_q;
    nd_d        = nd_q;
    neg_d       = neg_q;
    char_d      = char_q;
    last_d      = last_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (cmd_i.load) begin
      neg_d  = value_i[ValueW-1];
      mag_d  = value_i[ValueW-1] ? (~value_i + ValueW'(1)) : value_i;
      bcd_d  = '0;
      iter_d = '0;
      nd_d   = NdFull;
    end
    if (cmd_i.dabble) begin
      bcd_d  = {bcd_adj[BcdW-2:0], mag_q[ValueW-1]};
      mag_d  = {mag_q[ValueW-2:0], 1'b0};
      iter_d = iter_q + IterW'(1);
    end
    if (cmd_i.skip) begin
      bcd_d = {bcd_q[BcdW-5:0], 4'd0};
      nd_d  = nd_q - NdW'(1);
    end
    if (cmd_i.emit_sign) begin
      char_d      = CharMinus;
      last_d      = 1'b0;
      out_valid_d = 1'b1;
    end
    if (cmd_i.emit_digit) begin
      char_d      = CharZero + {2'b00, top_digit};
      last_d      = (nd_q == NdOne);
      out_valid_d = 1'b1;
      bcd_d       = {bcd_q[BcdW-5:0], 4'd0};
      nd_d        = nd_q - NdW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    bcd_q  <= bcd_d;
    iter_q <= iter_d;
    nd_q   <= nd_d;
    neg_q  <= neg_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign status_o.iter_done = (iter_q == IterLast);
  assign status_o.top_zero  = (top_digit == 4'd0);
  assign status_o.nd_one    = (nd_q == NdOne);
  assign status_o.neg       = neg_q;
  assign status_o.out_free  = !out_valid_q || !out_stall_i;

  assign character_o = char_q;
  assign last_o      = last_q;
  assign out_valid_o = out_valid_q;

endmodule

>>> rtl/core/signed_int_to_decimal_ascii_top.sv
// Sequence: after the input transaction come the shift-add-3 conversion steps, the
// skip of up to 9 leading zeros and a decision step; then the characters reach the
// output register, one character per cycle while the output is not stalled (up to 11).
// Only one number is in flight: a new input is taken only once the last character
// of the previous number has been emitted into the output register.
// Reset: rst_ni clears the controller state and the output valid flag.
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_top
// Converts a 32-bit signed integer to its decimal ASCII text, one character
// per output transaction, most significant first, final character flagged.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_top import itoa_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [ValueW-1:0] value_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic [CharW-1:0]  character_o,
  output logic              last_o,
  output logic              out_valid_o,
  input  logic              out_stall_i
);

  cmd_t    cmd;
  status_t status;

  itoa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  itoa_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .value_i     (value_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .character_o (character_o),
    .last_o      (last_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i)
  );

endmodule

>>> rtl/core/itoa_checker.sv
// ----------------------------------------------------------------------------
// itoa_checker
// Port-level checks for the integer to decimal text converter.
// ----------------------------------------------------------------------------
module itoa_checker import itoa_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic [ValueW-1:0] value_i,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic [CharW-1:0]  character_o,
  input logic              last_o,
  input logic              out_valid_o,
  input logic              out_stall_i
);

  // A new number is never taken right after one was accepted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted twice in a row");

  // Stalled input transaction holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_stall_o) |=> (in_valid_i && $stable(value_i)))
    else $error("stalled input changed");

  // Only minus sign and digits appear
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (character_o == CharMinus ||
                     (character_o >= CharZero && character_o <= CharZero + 6'd9)))
    else $error("character out of range");

  // A minus sign is never the final character
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && character_o == CharMinus) |-> !last_o)
    else $error("minus sign flagged last");

  // Stalled output transaction holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(character_o) && $stable(last_o)))
    else $error("stalled output changed");

endmodule

bind signed_int_to_decimal_ascii_top itoa_checker u_itoa_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .value_i     (value_i),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .character_o (character_o),
  .last_o      (last_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i)
);

>>> verif/tb_signed_int_to_decimal_ascii_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_signed_int_to_decimal_ascii_top
// Sends signed 32-bit integers into the converter and checks every character
// of the decimal text (and its last flag) against an in-bench prediction.
// Both handshake sides idle at random. One phase stalls the output for a
// long stretch, and one pauses the input until all text has come out.
// ----------------------------------------------------------------------------
module tb_signed_int_to_decimal_ascii_top;
  import itoa_pkg::*;

  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned DrainCycles = 60;

  typedef struct packed {
    logic [CharW-1:0] ch;
    logic             is_last;
  } text_char_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic [ValueW-1:0] value_i = '0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [CharW-1:0]  character_o;
  logic              last_o;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;

  text_char_t  pending_chars[$];
  text_char_t  expected_char;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;

  // Idling knobs shared by the stimulus and the receiver.
  bit          tx_idle_on = 1'b0;
  bit          rx_idle_on = 1'b0;
  int unsigned rx_hold_cycles = 0;
  int unsigned rx_burst_left = 0;

  signed_int_to_decimal_ascii_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .value_i     (value_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .character_o (character_o),
    .last_o      (last_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("** signed_int_to_decimal_ascii_top: FAILED **");
      $finish;
    end
  end

  // Queue the decimal text of one accepted value, most significant first.
  function automatic void predict_decimal_text(logic [ValueW-1:0] value);
    logic [ValueW-1:0] mag;
    logic [3:0]        digit[Digits];
    int                nd;
    text_char_t        c;
    mag = value[ValueW-1] ? (~value + 1'b1) : value;
    nd  = 0;
    do begin
      digit[nd] = 4'(mag % 10);
      mag       = mag / 10;
      nd++;
    end while (mag != 0 && nd < Digits);
    if (value[ValueW-1]) begin
      c.ch      = CharMinus;
      c.is_last = 1'b0;
      pending_chars.push_back(c);
    end
    for (int i = nd - 1; i >= 0; i--) begin
      c.ch      = CharW'(CharZero + digit[i]);
      c.is_last = (i == 0);
      pending_chars.push_back(c);
    end
  endfunction

  function automatic logic [ValueW-1:0] random_value();
    logic [ValueW-1:0] mag;
    longint unsigned   span;
    int unsigned       n;
    n    = $urandom_range(1, 9);
    span = 1;
    repeat (n) span *= 10;
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: mag = $urandom_range(0, 32'(span - 1));
      2: mag = 32'(span) + $urandom_range(0, 2) - 1;
      default: mag = $urandom_range(0, 20);
    endcase
    if ($urandom_range(0, 1) == 1) mag = -mag;
    return mag;
  endfunction

  // Offer one value and hold it until the transaction completes.
  task automatic send_value(logic [ValueW-1:0] value);
    @(negedge clk_i);
    value_i    <= value;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    predict_decimal_text(value);
  endtask

  // Drop valid for a random burst, scrambling the payload meanwhile.
  task automatic sender_gap();
    int unsigned n;
    if (tx_idle_on && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 14);
      @(negedge clk_i);
      in_valid_i <= 1'b0;
      value_i    <= $urandom;
      repeat (n - 1) begin
        @(negedge clk_i);
        value_i <= $urandom;
      end
    end
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_chars.size() != 0) @(posedge clk_i);
  endtask

  // Receiver: long hold-off first, then random stall bursts.
  initial begin
    forever begin
      @(negedge clk_i);
      if (rx_hold_cycles > 0) begin
        out_stall_i <= 1'b1;
        rx_hold_cycles--;
      end else if (rx_burst_left > 0) begin
        out_stall_i <= 1'b1;
        rx_burst_left--;
      end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
        out_stall_i   <= 1'b1;
        rx_burst_left = $urandom_range(1, 14) - 1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_chars.size() == 0) begin
        $error("unexpected character: character=%0d last=%0b", character_o, last_o);
        mismatches++;
      end else begin
        expected_char = pending_chars.pop_front();
        if (character_o !== expected_char.ch) begin
          $error("character: expected %0d, got %0d", expected_char.ch, character_o);
          mismatches++;
        end
        if (last_o !== expected_char.is_last) begin
          $error("last: expected %0b, got %0b", expected_char.is_last, last_o);
          mismatches++;
        end
      end
    end
  end

  task automatic test_directed_values();
    logic [ValueW-1:0] values[] = '{
      32'd0, 32'd1, -32'd1, 32'd9, -32'd9, 32'd10, -32'd10, 32'd99, 32'd100,
      -32'd100, 32'd12345, -32'd67890, 32'd999999999, 32'd1000000000,
      -32'd1000000000, 32'h7FFFFFFF, 32'h80000001, 32'h80000000,
      32'd1234567890, -32'd2000000000, 32'h55555555, 32'hAAAAAAAA
    };
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    foreach (values[i]) begin
      sender_gap();
      send_value(values[i]);
    end
    wait_drained();
  endtask

  // Hold the output off while values keep coming, so the input backs up.
  task automatic test_output_backpressure();
    tx_idle_on     = 1'b0;
    rx_idle_on     = 1'b0;
    rx_hold_cycles = 400;
    repeat (8) send_value(random_value());
    wait_drained();
  endtask

  task automatic test_random_values(int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        tx_idle_on = ($urandom_range(0, 3) != 0);
        rx_idle_on = ($urandom_range(0, 3) != 0);
      end
      sender_gap();
      send_value(random_value());
    end
  endtask

  // Pause the input until every character has come out, then resume.
  task automatic test_drain_pause();
    wait_drained();
    test_random_values(30);
  endtask

  task automatic test_no_idling(int unsigned count);
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    repeat (count) send_value(random_value());
    wait_drained();
  endtask

  initial begin
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed_values();
    test_output_backpressure();
    test_random_values(200);
    test_drain_pause();
    test_random_values(170);
    test_no_idling(80);

    repeat (DrainCycles) @(posedge clk_i);
    if (mismatches == 0 && pending_chars.size() == 0) begin
      $display("** signed_int_to_decimal_ascii_top: PASSED **");
    end else begin
      $display("** signed_int_to_decimal_ascii_top: FAILED **");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/itoa_pkg.sv
rtl/core/itoa_ctrl.sv
rtl/core/itoa_dp.sv
rtl/core/signed_int_to_decimal_ascii_top.sv
rtl/core/itoa_checker.sv
verif/tb_signed_int_to_decimal_ascii_top.sv
